>>> rtl/array_list_table_unit_macros.svh
// Assertion macros shared by the checker of array_list_table_unit.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ARRAY_LIST_TABLE_UNIT_MACROS_SVH
`define ARRAY_LIST_TABLE_UNIT_MACROS_SVH

// Same-cycle implication.
`define ALTU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ALTU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/altu_pkg.sv
// Shared types and constants of the array list table unit.
// No dependencies; imported by every other file but altu_ram and the macro header.
`timescale 1ns / 1ps
`default_nettype none

package altu_pkg;

	localparam int POS_W   = 9;
	localparam int VAL_W   = 32;
	localparam int QDEPTH  = 2;

	localparam logic [POS_W-1:0] FOUND_NONE = '1;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_ERASE  = 2'd1,
		KIND_GET    = 2'd2,
		KIND_SEARCH = 2'd3
	} altu_kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} altu_status_t;

	// Classified request handed from the front end to the back end.
	typedef struct packed {
		altu_kind_t         kind;
		altu_status_t       status;
		logic [POS_W-1:0]   pos;
		logic [VAL_W-1:0]   value;
	} altu_cmd_t;

endpackage

`default_nettype wire

>>> rtl/array_list_table_unit.sv
// Rejected requests go straight to the result; get reads one entry; insert
// moves each entry above the position up (a read, then a write) and writes the
// value; erase moves later entries down; search compares entries in order.
// Throughput: one request at a time in the back end; the front end takes up
// to two more meanwhile. Reset (arst_n low) empties the list and all queues.
`timescale 1ns / 1ps
`default_nettype none

module array_list_table_unit
	import altu_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// Request side: push a word while full is low.
	input  wire logic                      push,
	output logic                           full,
	input  wire logic [1:0]                kind,
	input  wire logic [POS_W-1:0]          position,
	input  wire logic signed [VAL_W-1:0]   value,
	// Result side: the oldest word waits while empty is low; pop takes it.
	output logic                           empty,
	input  wire logic                      pop,
	output logic [1:0]                     status,
	output logic signed [VAL_W-1:0]        read_value,
	output logic signed [POS_W-1:0]        found_position,
	output logic [POS_W-1:0]               count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int QW = $bits(altu_cmd_t) + CW;

	altu_cmd_t     f_cmd;
	logic [CW-1:0] f_cnt;
	logic          f_enq;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;
	logic [QW-1:0] q_data;
	altu_cmd_t     q_cmd;
	logic [CW-1:0] q_cnt;

	// Front end: check the position against the running count and
	// stamp each word with the count it sees.
	altu_front #(
		.CAPACITY (CAPACITY)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.kind     (kind),
		.position (position),
		.value    (value),
		.q_full   (q_full),
		.enq      (f_enq),
		.cmd      (f_cmd),
		.cnt      (f_cnt)
	);

	// Hold classified words until the back end is free.
	altu_queue #(
		.W (QW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_enq),
		.wr_data ({f_cmd, f_cnt}),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	assign q_cmd = q_data[QW-1:CW];
	assign q_cnt = q_data[CW-1:0];

	// Back end: walk the store one entry per access and drive the
	// result register.
	altu_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_cmd          (q_cmd),
		.q_cnt          (q_cnt),
		.q_pop          (q_pop),
		.pop            (pop),
		.empty          (empty),
		.status         (status),
		.read_value     (read_value),
		.found_position (found_position),
		.count          (count)
	);

endmodule

`default_nettype wire

>>> rtl/altu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module altu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/altu_queue.sv
// Short register queue between the front and back ends.
// Depends on altu_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none

module altu_queue
	import altu_pkg::*;
#(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic [W-1:0] wr_data,
	output logic              full,
	input  wire logic         rd_en,
	output logic      [W-1:0] rd_data,
	output logic              empty
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int FW = $clog2(QDEPTH + 1);

	logic [W-1:0]  slot_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [FW-1:0] fill_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (fill_q == FW'(QDEPTH));
	assign empty   = (fill_q == '0);
	assign rd_data = slot_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + FW'(1);
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

>>> rtl/altu_front.sv
// Front end: accepts requests, checks positions against the running count.
// Depends on altu_pkg; feeds altu_queue.
`timescale 1ns / 1ps
`default_nettype none

module altu_front
	import altu_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [1:0]                      kind,
	input  wire logic [POS_W-1:0]                position,
	input  wire logic signed [VAL_W-1:0]         value,
	input  wire logic                            q_full,
	output logic                                 enq,
	output altu_cmd_t                            cmd,
	output logic      [$clog2(CAPACITY+1)-1:0]   cnt
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_d;
	logic [CMPW-1:0] pos_x;
	logic [CMPW-1:0] cnt_x;
	altu_kind_t      kind_w;
	altu_status_t    status_w;

	assign kind_w = altu_kind_t'(kind);
	assign pos_x  = CMPW'(position);
	assign cnt_x  = CMPW'(count_q);
	assign full   = q_full;
	assign enq    = push && !q_full;

	// The count depends on positions only, so settle status here.
	always_comb begin
		status_w = ST_OK;
		count_d  = count_q;
		unique case (kind_w)
			KIND_INSERT: begin
				if (pos_x > cnt_x) begin
					status_w = ST_RANGE;
				end else if (count_q == CW'(CAPACITY)) begin
					status_w = ST_FULL;
				end else begin
					count_d = count_q + CW'(1);
				end
			end
			KIND_ERASE: begin
				if (pos_x >= cnt_x) begin
					status_w = ST_RANGE;
				end else begin
					count_d = count_q - CW'(1);
				end
			end
			KIND_GET: begin
				if (pos_x >= cnt_x) begin
					status_w = ST_RANGE;
				end
			end
			default: begin
				status_w = ST_OK;
			end
		endcase
	end

	assign cmd.kind   = kind_w;
	assign cmd.status = status_w;
	assign cmd.pos    = position;
	assign cmd.value  = value;
	assign cnt        = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (enq) begin
			count_q <= count_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/altu_back.sv
// Back end: carries out shifts, reads and searches on the entry store.
// Depends on altu_pkg and altu_ram; drains altu_queue.
`timescale 1ns / 1ps
`default_nettype none

module altu_back
	import altu_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_empty,
	input  wire altu_cmd_t                     q_cmd,
	input  wire logic [$clog2(CAPACITY+1)-1:0] q_cnt,
	output logic                               q_pop,
	input  wire logic                          pop,
	output logic                               empty,
	output logic [1:0]                         status,
	output logic signed [VAL_W-1:0]            read_value,
	output logic signed [POS_W-1:0]            found_position,
	output logic [POS_W-1:0]                   count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_MOVE_RD  = 9'b000000010,
		S_MOVE_WR  = 9'b000000100,
		S_INS_PUT  = 9'b000001000,
		S_GET_RD   = 9'b000010000,
		S_GET_CAP  = 9'b000100000,
		S_SRCH_RD  = 9'b001000000,
		S_SRCH_CMP = 9'b010000000,
		S_DONE     = 9'b100000000
	} altu_state_t;

	altu_state_t       state_q;
	altu_state_t       state_d;
	altu_cmd_t         cmd_q;
	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     idx_d;
	logic [VAL_W-1:0]  rd_q;
	logic [POS_W-1:0]  found_q;
	logic              found_hit;
	logic              out_valid_q;
	logic              out_take;
	logic [1:0]        out_status_q;
	logic [VAL_W-1:0]  out_read_q;
	logic [POS_W-1:0]  out_found_q;
	logic [POS_W-1:0]  out_count_q;
	logic [CW-1:0]     cnt_after;
	logic [AW-1:0]     pos_idx;
	logic [AW-1:0]     q_pos_idx;
	logic [CW-1:0]     q_pos_c;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [VAL_W-1:0]  ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [VAL_W-1:0]  ram_rdata;

	altu_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign q_pop     = (state_q == S_IDLE) && !q_empty;
	assign pos_idx   = AW'(cmd_q.pos);
	assign q_pos_idx = AW'(q_cmd.pos);
	assign q_pos_c   = CW'(q_pos_idx);
	assign out_take  = (state_q == S_DONE) && (!out_valid_q || pop);

	// Insert moves entries up from the top, erase moves them down.
	always_comb begin
		unique case (state_q)
			S_MOVE_RD: begin
				ram_raddr = (cmd_q.kind == KIND_INSERT) ? idx_q - AW'(1) : idx_q + AW'(1);
			end
			S_GET_RD:  ram_raddr = pos_idx;
			default:   ram_raddr = idx_q;
		endcase
	end

	assign ram_we    = (state_q == S_MOVE_WR) || (state_q == S_INS_PUT);
	assign ram_waddr = (state_q == S_INS_PUT) ? pos_idx : idx_q;
	assign ram_wdata = (state_q == S_INS_PUT) ? cmd_q.value : ram_rdata;

	always_comb begin
		cnt_after = cnt_q;
		if (cmd_q.status == ST_OK) begin
			if (cmd_q.kind == KIND_INSERT) begin
				cnt_after = cnt_q + CW'(1);
			end else if (cmd_q.kind == KIND_ERASE) begin
				cnt_after = cnt_q - CW'(1);
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		found_hit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					if (q_cmd.status != ST_OK) begin
						state_d = S_DONE;
					end else begin
						case (q_cmd.kind)
							KIND_INSERT: begin
								if (q_pos_c == q_cnt) begin
									state_d = S_INS_PUT;
								end else begin
									idx_d   = AW'(q_cnt);
									state_d = S_MOVE_RD;
								end
							end
							KIND_ERASE: begin
								if (q_pos_c + CW'(1) == q_cnt) begin
									state_d = S_DONE;
								end else begin
									idx_d   = q_pos_idx;
									state_d = S_MOVE_RD;
								end
							end
							KIND_GET: state_d = S_GET_RD;
							default: begin
								if (q_cnt == '0) begin
									state_d = S_DONE;
								end else begin
									idx_d   = '0;
									state_d = S_SRCH_RD;
								end
							end
						endcase
					end
				end
			end
			S_MOVE_RD: state_d = S_MOVE_WR;
			S_MOVE_WR: begin
				if (cmd_q.kind == KIND_INSERT) begin
					if (idx_q - AW'(1) == pos_idx) begin
						state_d = S_INS_PUT;
					end else begin
						idx_d   = idx_q - AW'(1);
						state_d = S_MOVE_RD;
					end
				end else begin
					if (CW'(idx_q) + CW'(2) == cnt_q) begin
						state_d = S_DONE;
					end else begin
						idx_d   = idx_q + AW'(1);
						state_d = S_MOVE_RD;
					end
				end
			end
			S_INS_PUT: state_d = S_DONE;
			S_GET_RD:  state_d = S_GET_CAP;
			S_GET_CAP: state_d = S_DONE;
			S_SRCH_RD: state_d = S_SRCH_CMP;
			S_SRCH_CMP: begin
				if (ram_rdata == cmd_q.value) begin
					found_hit = 1'b1;
					state_d   = S_DONE;
				end else if (CW'(idx_q) + CW'(1) == cnt_q) begin
					state_d = S_DONE;
				end else begin
					idx_d   = idx_q + AW'(1);
					state_d = S_SRCH_RD;
				end
			end
			S_DONE: begin
				if (out_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_take) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (q_pop) begin
			cmd_q   <= q_cmd;
			cnt_q   <= q_cnt;
			rd_q    <= '0;
			found_q <= (q_cmd.kind == KIND_SEARCH) ? FOUND_NONE : '0;
		end
		if (state_q == S_GET_CAP) begin
			rd_q <= ram_rdata;
		end
		if (found_hit) begin
			found_q <= POS_W'(idx_q);
		end
		if (out_take) begin
			out_status_q <= cmd_q.status;
			out_read_q   <= rd_q;
			out_found_q  <= found_q;
			out_count_q  <= POS_W'(cnt_after);
		end
	end

	assign empty          = !out_valid_q;
	assign status         = out_status_q;
	assign read_value     = out_read_q;
	assign found_position = out_found_q;
	assign count          = out_count_q;

endmodule

`default_nettype wire

>>> rtl/altu_check.sv
// Port-level checker for array_list_table_unit, attached by bind.
// Depends on altu_pkg and array_list_table_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "array_list_table_unit_macros.svh"

module altu_check
	import altu_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    empty,
	input wire logic                    pop,
	input wire logic [1:0]              status,
	input wire logic signed [VAL_W-1:0] read_value,
	input wire logic signed [POS_W-1:0] found_position,
	input wire logic [POS_W-1:0]        count
);

	`ALTU_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(status) && $stable(read_value) && $stable(found_position) && $stable(count), "result changed while stalled")

	`ALTU_ASSERT_NOW(a_full_count, !empty && status == ST_FULL, count == POS_W'(CAPACITY), "full status without a full list")

	`ALTU_ASSERT_NOW(a_error_clean, !empty && status != ST_OK, read_value == 0 && found_position == 0, "rejected request carries data")

	`ALTU_ASSERT_NOW(a_found_search, !empty && found_position != 0, status == ST_OK && read_value == 0, "search result mixed with read data")

endmodule

bind array_list_table_unit altu_check #(
	.CAPACITY (CAPACITY)
) u_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.status         (status),
	.read_value     (read_value),
	.found_position (found_position),
	.count          (count)
);

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking bench for array_list_table_unit: mirrors the ordered list in a
// scoreboard class and checks every result word field by field, in order.
// Depends on altu_pkg and the array_list_table_unit RTL; nothing else.
`timescale 1ns / 1ps

module testbench;
	import altu_pkg::*;

	localparam int LIST_CAP = 256;

	// One expected result word.
	typedef struct {
		altu_status_t       status;
		logic [VAL_W-1:0]   read_value;
		logic [POS_W-1:0]   found_position;
		logic [POS_W-1:0]   count;
	} list_result_t;

	// Mirror of the list contents plus the queue of result words still owed
	// by the block. Requests are noted in acceptance order, results are
	// checked in pop order, so the queue head is always the next word out.
	class list_mirror;
		logic [VAL_W-1:0] held_entries [LIST_CAP];
		int               held;
		list_result_t     awaited [$];
		int               failures;

		function new();
			held = 0;
			failures = 0;
			foreach (held_entries[i])
				held_entries[i] = '0;
		endfunction

		function int held_count();
			return held;
		endfunction

		function logic [VAL_W-1:0] entry_at(int idx);
			return held_entries[idx];
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// Apply one accepted request to the mirror and queue its result word.
		function void note_request(altu_kind_t k, logic [POS_W-1:0] pos,
				logic [VAL_W-1:0] val);
			list_result_t r;
			int p;
			int i;
			p = pos;
			r.status = ST_OK;
			r.read_value = '0;
			r.found_position = '0;
			case (k)
				KIND_INSERT: begin
					if (p > held) begin
						r.status = ST_RANGE;
					end else if (held >= LIST_CAP) begin
						r.status = ST_FULL;
					end else begin
						for (i = held; i > p; i--)
							held_entries[i] = held_entries[i-1];
						held_entries[p] = val;
						held++;
					end
				end
				KIND_ERASE: begin
					if (p >= held) begin
						r.status = ST_RANGE;
					end else begin
						for (i = p; i + 1 < held; i++)
							held_entries[i] = held_entries[i+1];
						held--;
						held_entries[held] = '0;
					end
				end
				KIND_GET: begin
					if (p >= held)
						r.status = ST_RANGE;
					else
						r.read_value = held_entries[p];
				end
				default: begin
					// Search: first match wins, none found reads as all ones.
					r.found_position = FOUND_NONE;
					for (i = 0; i < held; i++) begin
						if (held_entries[i] == val) begin
							r.found_position = POS_W'(i);
							break;
						end
					end
				end
			endcase
			r.count = POS_W'(held);
			awaited.push_back(r);
		endfunction

		function void report_mismatch(string field, logic [31:0] want, logic [31:0] got);
			failures++;
			$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
		endfunction

		// Compare one popped result word against the oldest expectation.
		function void check_result(logic [1:0] st, logic [VAL_W-1:0] rv,
				logic [POS_W-1:0] fp, logic [POS_W-1:0] cn);
			list_result_t e;
			if (awaited.size() == 0) begin
				failures++;
				$error("result word popped with no request pending");
				return;
			end
			e = awaited.pop_front();
			if (st !== e.status)
				report_mismatch("status", e.status, st);
			if (rv !== e.read_value)
				report_mismatch("read_value", e.read_value, rv);
			if (fp !== e.found_position)
				report_mismatch("found_position", e.found_position, fp);
			if (cn !== e.count)
				report_mismatch("count", e.count, cn);
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      push = 1'b0;
	logic                      full;
	logic [1:0]                kind = KIND_INSERT;
	logic [POS_W-1:0]          position = '0;
	logic signed [VAL_W-1:0]   value = '0;
	logic                      empty;
	logic                      pop = 1'b0;
	logic [1:0]                status;
	logic signed [VAL_W-1:0]   read_value;
	logic signed [POS_W-1:0]   found_position;
	logic [POS_W-1:0]          count;

	list_mirror mirror = new();

	// Quiet mode turns off all idling on both sides for the closing stretch.
	bit quiet = 1'b0;
	int tx_idle_pct = 20;
	int rx_idle_pct = 20;
	int rx_stall_left = 0;
	int rx_tick = 0;

	array_list_table_unit #(
		.CAPACITY(LIST_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.kind(kind),
		.position(position),
		.value(value),
		.empty(empty),
		.pop(pop),
		.status(status),
		.read_value(read_value),
		.found_position(found_position),
		.count(count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 0;
	end

	// Result side: check the word taken at this edge, then pick pop for the
	// next edge. Stalls come in bursts, and the stall rate is rerolled by rx_tick
	// so that calm stretches show up as well.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				mirror.check_result(status, read_value, found_position, count);
			if (rx_tick % 64 == 0)
				rx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
			rx_tick++;
			if (rx_stall_left > 0) begin
				rx_stall_left--;
				pop <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
				rx_stall_left = $urandom_range(0, 10);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Push one request word and hold it until the block takes it. Push stays
	// high across back-to-back words; it only drops for an idle burst or in wait_drained.
	task automatic send_request(altu_kind_t k, int pos, logic [VAL_W-1:0] val);
		int gap;
		if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
			push <= 1'b0;
			gap = $urandom_range(1, 11);
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		kind <= k;
		position <= POS_W'(pos);
		value <= val;
		@(posedge clk);
		while (full)
			@(posedge clk);
		mirror.note_request(k, POS_W'(pos), val);
	endtask

	// Drop push and hold off until every owed result word has been popped.
	task automatic wait_drained();
		push <= 1'b0;
		while (mirror.pending() != 0)
			@(posedge clk);
	endtask

	// Random traffic on a short list: the insert/erase mix keeps the count
	// around limit, so latencies stay small. Searches mostly look for a value
	// that is held, inserts sometimes repeat one to create duplicates.
	task automatic random_small_ops(int items, int limit);
		int n;
		int held;
		int roll;
		int pos;
		altu_kind_t k;
		logic [VAL_W-1:0] val;
		for (n = 0; n < items; n++) begin
			if (n % 50 == 0)
				tx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
			held = mirror.held_count();
			roll = $urandom_range(0, 99);
			if (roll < 35)
				k = (held >= limit) ? KIND_ERASE : KIND_INSERT;
			else if (roll < 55)
				k = (held == 0 && $urandom_range(0, 1) == 1) ? KIND_INSERT : KIND_ERASE;
			else if (roll < 75)
				k = KIND_GET;
			else
				k = KIND_SEARCH;

			// Mostly legal positions; one in ten at or past the end.
			if (k == KIND_SEARCH || $urandom_range(0, 9) == 0)
				pos = ($urandom_range(0, 1) == 1) ? LIST_CAP : $urandom_range(held, LIST_CAP);
			else if (k == KIND_INSERT)
				pos = $urandom_range(0, held);
			else
				pos = (held == 0) ? 0 : $urandom_range(0, held - 1);

			roll = $urandom_range(0, 9);
			if (held > 0 && ((k == KIND_SEARCH) ? (roll < 6) : (roll < 2)))
				val = mirror.entry_at($urandom_range(0, held - 1));
			else if (roll == 9)
				val = ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			else if (roll == 8)
				val = $urandom_range(0, 3);
			else
				val = $urandom();
			send_request(k, pos, val);
		end
	endtask

	initial begin
		int fill_pos;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-list requests first, then a five-entry list built
		// from the value extremes with a duplicate, then reads, searches and
		// erases at the front, middle and end.
		send_request(KIND_GET, 0, '0);
		send_request(KIND_ERASE, 0, '0);
		send_request(KIND_SEARCH, 0, '0);
		send_request(KIND_INSERT, 1, 32'h1);
		send_request(KIND_INSERT, LIST_CAP, 32'h2);
		send_request(KIND_INSERT, 0, 32'h8000_0000);
		send_request(KIND_INSERT, 1, 32'h7FFF_FFFF);
		send_request(KIND_INSERT, 0, 32'hFFFF_FFFF);
		send_request(KIND_INSERT, 1, 32'h0);
		send_request(KIND_INSERT, 2, 32'h7FFF_FFFF);
		send_request(KIND_GET, 0, '0);
		send_request(KIND_GET, 4, '0);
		send_request(KIND_GET, 5, '0);
		send_request(KIND_SEARCH, 0, 32'h7FFF_FFFF);
		send_request(KIND_SEARCH, 0, 32'h8000_0000);
		send_request(KIND_SEARCH, LIST_CAP, 32'h0001_2345);
		send_request(KIND_ERASE, 4, '0);
		send_request(KIND_ERASE, 0, '0);
		send_request(KIND_ERASE, 1, '0);
		send_request(KIND_ERASE, LIST_CAP, '0);
		send_request(KIND_GET, LIST_CAP, '0);

		// Let the block run dry once before the random traffic.
		wait_drained();

		random_small_ops(600, 24);

		// Fill to capacity, mostly appending, sometimes inserting in the
		// middle. Then hit the full list and walk it back down to empty.
		while (mirror.held_count() < LIST_CAP) begin
			fill_pos = mirror.held_count();
			if ($urandom_range(0, 7) == 0)
				fill_pos = $urandom_range(0, fill_pos);
			send_request(KIND_INSERT, fill_pos, $urandom());
		end
		send_request(KIND_INSERT, LIST_CAP, 32'h0);
		send_request(KIND_INSERT, 0, 32'h1234_5678);
		send_request(KIND_GET, LIST_CAP - 1, '0);
		send_request(KIND_GET, LIST_CAP, '0);
		send_request(KIND_SEARCH, 0, mirror.entry_at(LIST_CAP - 1));
		send_request(KIND_SEARCH, 0, $urandom());
		send_request(KIND_ERASE, LIST_CAP, '0);
		send_request(KIND_ERASE, 0, '0);
		send_request(KIND_INSERT, LIST_CAP - 1, 32'h7FFF_FFFF);
		// Position equals count, so it passes the range test and is full.
		send_request(KIND_INSERT, LIST_CAP, 32'h0);
		while (mirror.held_count() > 0) begin
			fill_pos = mirror.held_count() - 1;
			if ($urandom_range(0, 7) == 0)
				fill_pos = $urandom_range(0, fill_pos);
			send_request(KIND_ERASE, fill_pos, '0);
		end

		wait_drained();
		random_small_ops(600, 40);

		// Closing stretch at full rate on both sides.
		quiet = 1'b1;
		random_small_ops(200, 12);

		wait_drained();
		// Give a stray extra word time to show up and get flagged.
		repeat (600) @(posedge clk);
		if (mirror.failures == 0 && mirror.pending() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#120_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/altu_pkg.sv
rtl/altu_ram.sv
rtl/altu_queue.sv
rtl/altu_front.sv
rtl/altu_back.sv
rtl/array_list_table_unit.sv
rtl/altu_check.sv
tb/sv/testbench.sv
